// ----- hw/rtl/sha_pkg.sv -----
`timescale 1ns / 1ps
package sha_pkg;

  localparam logic [31:0] RoundK [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  localparam logic [31:0] InitH [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [6:0] LenPos  = 7'd56;

  localparam logic CmdAbsorb = 1'b0;
  localparam logic CmdFinish = 1'b1;

  typedef struct packed {
    logic start;
    logic init;
  } cmp_ctl_t;

  function automatic logic [31:0] big0(input logic [31:0] x);
    big0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big1(input logic [31:0] x);
    big1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] sml0(input logic [31:0] x);
    sml0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] sml1(input logic [31:0] x);
    sml1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

// ----- hw/rtl/sha_msg_sched.sv -----
`timescale 1ns / 1ps
module sha_msg_sched (
  input  logic        clk_i,
  input  logic        wr_en_i,
  input  logic [5:0]  wr_idx_i,
  input  logic [7:0]  wr_byte_i,
  input  logic        len_en_i,
  input  logic [63:0] len_i,
  input  logic        shift_i,
  output logic [31:0] w_o
);

  logic [31:0] win_q [16];
  logic [31:0] nxt;

  // The window slides by one word per round; word 0 is the current round word.
  assign nxt = sha_pkg::sml1(win_q[14]) + win_q[9] + sha_pkg::sml0(win_q[1]) + win_q[0];
  assign w_o = win_q[0];

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      for (int i = 0; i < 15; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[15] <= nxt;
    end else if (len_en_i) begin
      win_q[14] <= len_i[63:32];
      win_q[15] <= len_i[31:0];
    end else if (wr_en_i) begin
      case (wr_idx_i[1:0])
        2'd0:    win_q[wr_idx_i[5:2]][31:24] <= wr_byte_i;
        2'd1:    win_q[wr_idx_i[5:2]][23:16] <= wr_byte_i;
        2'd2:    win_q[wr_idx_i[5:2]][15:8]  <= wr_byte_i;
        default: win_q[wr_idx_i[5:2]][7:0]   <= wr_byte_i;
      endcase
    end
  end

endmodule

// ----- hw/rtl/sha_compress.sv -----
`timescale 1ns / 1ps
module sha_compress (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sha_pkg::cmp_ctl_t ctl_i,
  input  logic [31:0]      w_i,
  input  logic [2:0]       rd_idx_i,
  output logic [31:0]      rd_data_o,
  output logic             busy_o,
  output logic             done_o
);

  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [5:0]  rnd_q;
  logic        run_q;
  logic        add_q;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] ch;
  logic [31:0] maj;

  assign ch  = v_q[6] ^ (v_q[4] & (v_q[5] ^ v_q[6]));
  assign maj = (v_q[0] & v_q[1]) | (v_q[2] & (v_q[0] | v_q[1]));
  assign t1  = v_q[7] + sha_pkg::big1(v_q[4]) + ch + sha_pkg::RoundK[rnd_q] + w_i;
  assign t2  = sha_pkg::big0(v_q[0]) + maj;

  assign rd_data_o = h_q[rd_idx_i];
  assign busy_o    = run_q;
  assign done_o    = add_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      add_q <= 1'b0;
      rnd_q <= '0;
      for (int i = 0; i < 8; i++) begin
        h_q[i] <= sha_pkg::InitH[i];
      end
    end else begin
      add_q <= 1'b0;
      if (ctl_i.start) begin
        run_q <= 1'b1;
        rnd_q <= '0;
      end else if (run_q) begin
        rnd_q <= rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          run_q <= 1'b0;
          add_q <= 1'b1;
        end
      end
      if (ctl_i.init) begin
        for (int i = 0; i < 8; i++) begin
          h_q[i] <= sha_pkg::InitH[i];
        end
      end else if (add_q) begin
        for (int i = 0; i < 8; i++) begin
          h_q[i] <= h_q[i] + v_q[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      for (int i = 0; i < 8; i++) begin
        v_q[i] <= h_q[i];
      end
    end else if (run_q) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

endmodule

// ----- hw/rtl/sha256_byte_stream_hasher.sv -----
`timescale 1ns / 1ps
// Absorb beat: taken while idle; one that completes a 64-byte block is followed by the
// 64 rounds of one shared round unit and then the hash update.
// Finish beat: one padding byte per cycle up to byte 56 or 64, then rounds and hash update
// per padded block (one or two blocks), then eight output beats. Input stalls outside idle.
// Reset (asynchronous, active low) loads the initial hash value and a zero byte count;
// the same happens after the eighth digest word is taken.
module sha256_byte_stream_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_COMP = 2'd1;
  localparam logic [1:0] ST_PAD  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]  state_q;
  logic [60:0] cnt_q;
  logic [6:0]  ptr_q;
  logic        fin_q;
  logic        ovf_q;
  logic        lenblk_q;
  logic [2:0]  oidx_q;

  logic        in_acc;
  logic        out_acc;
  logic [5:0]  pos;
  logic        pad_len;
  logic        pad_full;
  logic        wr_en;
  logic [5:0]  wr_idx;
  logic [7:0]  wr_byte;
  logic [31:0] w_word;
  logic        cmp_busy;
  logic        cmp_done;
  sha_pkg::cmp_ctl_t ctl;

  assign pos      = cnt_q[5:0];
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign in_acc   = in_valid_i & ~in_stall_o;
  assign out_acc  = out_valid_o & ~out_stall_i;

  // Length goes in once zeros reach byte 56; an overflowing block is zeroed to its end.
  assign pad_len  = (state_q == ST_PAD) && !ovf_q && (ptr_q == sha_pkg::LenPos);
  assign pad_full = (state_q == ST_PAD) && ptr_q[6];

  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = pos;
    wr_byte = data_byte_i;
    if (in_acc) begin
      wr_en   = 1'b1;
      wr_byte = (command_i == sha_pkg::CmdFinish) ? sha_pkg::PadByte : data_byte_i;
    end else if ((state_q == ST_PAD) && !pad_len && !pad_full) begin
      wr_en   = 1'b1;
      wr_idx  = ptr_q[5:0];
      wr_byte = 8'h00;
    end
  end

  assign ctl.start = (in_acc && (command_i == sha_pkg::CmdAbsorb) && (pos == 6'd63))
                     || pad_len || pad_full;
  assign ctl.init  = out_acc && (oidx_q == 3'd7);

  sha_msg_sched u_sched (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_idx_i  (wr_idx),
    .wr_byte_i (wr_byte),
    .len_en_i  (pad_len),
    .len_i     ({cnt_q, 3'b000}),
    .shift_i   (cmp_busy),
    .w_o       (w_word)
  );

  sha_compress u_comp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .w_i       (w_word),
    .rd_idx_i  (oidx_q),
    .rd_data_o (digest_word_o),
    .busy_o    (cmp_busy),
    .done_o    (cmp_done)
  );

  assign word_index_o = oidx_q;
  assign last_word_o  = (oidx_q == 3'd7);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      ptr_q    <= '0;
      fin_q    <= 1'b0;
      ovf_q    <= 1'b0;
      lenblk_q <= 1'b0;
      oidx_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (command_i == sha_pkg::CmdFinish) begin
              fin_q    <= 1'b1;
              ptr_q    <= {1'b0, pos} + 7'd1;
              ovf_q    <= (pos >= 6'd56);
              lenblk_q <= 1'b0;
              state_q  <= ST_PAD;
            end else begin
              cnt_q <= cnt_q + 61'd1;
              if (pos == 6'd63) begin
                state_q <= ST_COMP;
              end
            end
          end
        end
        ST_PAD: begin
          if (pad_len) begin
            lenblk_q <= 1'b1;
            state_q  <= ST_COMP;
          end else if (pad_full) begin
            ovf_q   <= 1'b0;
            ptr_q   <= '0;
            state_q <= ST_COMP;
          end else begin
            ptr_q <= ptr_q + 7'd1;
          end
        end
        ST_COMP: begin
          if (cmp_done) begin
            if (!fin_q) begin
              state_q <= ST_IDLE;
            end else if (lenblk_q) begin
              oidx_q  <= '0;
              state_q <= ST_OUT;
            end else begin
              state_q <= ST_PAD;
            end
          end
        end
        ST_OUT: begin
          if (out_acc) begin
            oidx_q <= oidx_q + 3'd1;
            if (oidx_q == 3'd7) begin
              fin_q   <= 1'b0;
              cnt_q   <= '0;
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_out_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !cmp_busy)
    else $error("digest shown while rounds run");

  a_done_in_comp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_done |-> (state_q == ST_COMP))
    else $error("compression finished outside compress state");

  a_full_block_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (command_i == sha_pkg::CmdAbsorb) && (pos == 6'd63)) |=> cmp_busy)
    else $error("full block did not start compression");

  a_ready_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && last_word_o) |=> !in_stall_o)
    else $error("not ready after last digest beat");

endmodule
